// File: hw/rtl/cbbm_pkg.sv
// Shared types and constants of the compressed block bit map builder.
package cbbm_pkg;

    localparam int unsigned BLOCK_BITS_W = 29;
    localparam int unsigned SKIP_W       = 3;
    localparam int unsigned OFFSET_W     = 45;
    localparam int unsigned SIZE_W       = 46;
    localparam int unsigned FOOTER_BYTES = 8;
    localparam int unsigned RESULTS_MAX  = 3;

    typedef enum logic [1:0] {
        KIND_BLOCK   = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_BLOCK_SIZE   = 2'd0,
        REG_BLOCK_COUNT  = 2'd1,
        REG_TOTAL_LENGTH = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [31:0] block_size;
        logic [31:0] block_count;
        logic [39:0] total_length;
    } cfg_t;

    // running state apart from the bit position, whose width is a parameter
    typedef struct packed {
        logic [31:0]         group_outs;
        logic [31:0]         group_bits;
        logic [31:0]         blocks_emitted;
        logic [47:0]         outs_sum;
        logic [OFFSET_W-1:0] first_byte_offset;
        logic                failed;
    } run_state_t;

    typedef struct packed {
        kind_t                   kind;
        logic [31:0]             block_index;
        logic [SKIP_W-1:0]       skip_bits;
        logic [BLOCK_BITS_W-1:0] bit_size;
        logic [OFFSET_W-1:0]     data_offset;
        logic [SIZE_W-1:0]       sync_data_size;
        logic                    ok;
        logic                    last;
    } result_t;

endpackage

// File: hw/rtl/compressed_block_bit_map_builder_top.sv
// Top level of the compressed block bit map builder.
//
// Map entries arrive on the s_ stream (bit count, output byte count, tlast on the final
// entry) and results leave on the m_ stream, kind in tuser. An entry is registered, then
// worked out combinationally against the running accumulators, and its results (up to two
// block records and a summary or an error) are loaded into a three-slot result buffer
// once the buffer is free; the first result is offered from the buffer slot registers,
// after the input register. An entry can be taken every cycle while each entry
// gives at most one result and m_tready is high; an entry that gives more results
// holds the next one while the buffer drains, one result per transfer.
// The user must write registers on the cfg_ channel only while no entry is in flight;
// the block does not enforce it. There is no clearing pass after reset.
module compressed_block_bit_map_builder_top import cbbm_pkg::*; #(
    parameter int unsigned POS_WIDTH = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // bit_count[15:0], out_count[30:16], zero[31]
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // block_index[31:0], skip_bits[34:32], bit_size[63:35], data_offset[108:64],
    // sync_data_size[154:109], ok[155], zero[159:156]
    output logic [159:0] m_tdata,
    output logic [1:0]   m_tuser,   // kind[1:0]
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [39:0]  cfg_data
);

    cfg_t                 cfg_reg;
    run_state_t           st_reg;
    run_state_t           st_next;
    logic [POS_WIDTH-1:0] bit_pos_reg;
    logic [POS_WIDTH-1:0] bit_pos_next;
    logic                 item_valid_reg;
    logic [15:0]          item_bits_reg;
    logic [14:0]          item_outs_reg;
    logic                 item_last_reg;
    result_t [RESULTS_MAX-1:0] step_results;
    logic [1:0]           step_count;
    logic                 buf_free;
    logic                 fire;
    result_t              out_result;

    assign cfg_ready = 1'b1;
    assign fire      = item_valid_reg && buf_free;
    assign s_tready  = !item_valid_reg || buf_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.block_size   <= 32'd2048;
            cfg_reg.block_count  <= 32'd1;
            cfg_reg.total_length <= 40'd1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_BLOCK_SIZE:   cfg_reg.block_size   <= cfg_data[31:0];
                REG_BLOCK_COUNT:  cfg_reg.block_count  <= cfg_data[31:0];
                REG_TOTAL_LENGTH: cfg_reg.total_length <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            item_valid_reg <= 1'b1;
        end else if (fire) begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_bits_reg <= s_tdata[15:0];
            item_outs_reg <= s_tdata[30:16];
            item_last_reg <= s_tlast;
        end
    end

    // advance the accumulators as the entry's results go into the buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= '0;
            bit_pos_reg <= '0;
        end else if (fire) begin
            st_reg      <= st_next;
            bit_pos_reg <= bit_pos_next;
        end
    end

    cbbm_step #(
        .POS_WIDTH(POS_WIDTH)
    ) u_step (
        .cfg          (cfg_reg),
        .st           (st_reg),
        .bit_pos      (bit_pos_reg),
        .bit_count    (item_bits_reg),
        .out_count    (item_outs_reg),
        .is_last      (item_last_reg),
        .st_next      (st_next),
        .bit_pos_next (bit_pos_next),
        .results      (step_results),
        .result_count (step_count)
    );

    cbbm_out_buf u_out_buf (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (fire),
        .load_results (step_results),
        .load_count   (step_count),
        .free         (buf_free),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_result   (out_result)
    );

    assign m_tdata = {4'b0, out_result.ok, out_result.sync_data_size,
                      out_result.data_offset, out_result.bit_size,
                      out_result.skip_bits, out_result.block_index};
    assign m_tuser = out_result.kind;
    assign m_tlast = out_result.last;

    a_final_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != KIND_BLOCK) |-> m_tlast)
        else $error("summary or error result without tlast");

    a_block_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_BLOCK) |-> (m_tdata[63:35] != '0))
        else $error("block record with zero bit size");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_ERROR) |-> (m_tdata == '0))
        else $error("error result carries data");

    a_map_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item_last_reg |=> (bit_pos_reg == '0) && !st_reg.failed &&
                                  (st_reg.blocks_emitted == '0))
        else $error("state not cleared after final entry");

endmodule

// File: hw/rtl/cbbm_step.sv
// Per-entry datapath: next running state and up to three results of one map entry.
module cbbm_step import cbbm_pkg::*; #(
    parameter int unsigned POS_WIDTH = 48
) (
    input  cfg_t                        cfg,
    input  run_state_t                  st,
    input  logic [POS_WIDTH-1:0]        bit_pos,
    input  logic [15:0]                 bit_count,
    input  logic [14:0]                 out_count,
    input  logic                        is_last,
    output run_state_t                  st_next,
    output logic [POS_WIDTH-1:0]        bit_pos_next,
    output result_t [RESULTS_MAX-1:0]   results,
    output logic [1:0]                  result_count
);

    localparam int unsigned EXT_W = POS_WIDTH + 48;

    always_comb begin
        logic [31:0]          go;
        logic [31:0]          gb;
        logic [31:0]          be;
        logic [OFFSET_W-1:0]  fbo;
        logic [POS_WIDTH-1:0] bp;
        logic [48:0]          sum49;
        logic [47:0]          outs_sum_n;
        logic [32:0]          sum33;
        logic [EXT_W-1:0]     ext;
        logic [EXT_W-1:0]     size_ext;
        logic                 err;
        logic                 skip;
        logic [1:0]           k;

        go   = st.group_outs;
        gb   = st.group_bits;
        be   = st.blocks_emitted;
        fbo  = st.first_byte_offset;
        bp   = bit_pos;
        err  = 1'b0;
        k    = 2'd0;
        results = '0;
        sum49 = {1'b0, st.outs_sum} + 49'(out_count);
        outs_sum_n = sum49[48] ? '1 : sum49[47:0];
        st_next = st;
        bit_pos_next = bit_pos;
        skip = 1'b0;
        sum33 = '0;
        ext = '0;
        size_ext = '0;

        if (st.failed) begin
            if (is_last) begin
                results[0].kind = KIND_ERROR;
                k = 2'd1;
            end
        end else begin
            skip = (out_count == '0) &&
                   (((be == '0) && (go == '0)) || (be >= cfg.block_count));
            if (skip) begin
                bp = bp + POS_WIDTH'(bit_count);
            end else begin
                // overfull: close the group first if it is exactly full
                if (({1'b0, go} + 33'(out_count)) > {1'b0, cfg.block_size}) begin
                    if (go != cfg.block_size || be >= cfg.block_count ||
                        gb == '0 || gb[31:BLOCK_BITS_W] != '0) begin
                        err = 1'b1;
                    end else begin
                        ext = EXT_W'(bp);
                        if (be == '0) fbo = ext[OFFSET_W+2:3];
                        results[k].kind        = KIND_BLOCK;
                        results[k].block_index = be;
                        results[k].skip_bits   = bp[SKIP_W-1:0];
                        results[k].bit_size    = gb[BLOCK_BITS_W-1:0];
                        results[k].data_offset = fbo;
                        k  = k + 2'd1;
                        be = be + 32'd1;
                        bp = bp + POS_WIDTH'(gb);
                        go = '0;
                        gb = '0;
                    end
                end
                if (!err) begin
                    go = go + 32'(out_count);
                    sum33 = {1'b0, gb} + 33'(bit_count);
                    gb = sum33[32] ? '1 : sum33[31:0];
                end
            end

            // flush the open group on the final entry
            if (!err && is_last && go != '0) begin
                if (go > cfg.block_size || be >= cfg.block_count ||
                    gb == '0 || gb[31:BLOCK_BITS_W] != '0) begin
                    err = 1'b1;
                end else begin
                    ext = EXT_W'(bp);
                    if (be == '0) fbo = ext[OFFSET_W+2:3];
                    results[k].kind        = KIND_BLOCK;
                    results[k].block_index = be;
                    results[k].skip_bits   = bp[SKIP_W-1:0];
                    results[k].bit_size    = gb[BLOCK_BITS_W-1:0];
                    results[k].data_offset = fbo;
                    k  = k + 2'd1;
                    be = be + 32'd1;
                    bp = bp + POS_WIDTH'(gb);
                    go = '0;
                    gb = '0;
                end
            end

            if (err) begin
                results[k]      = '0;
                results[k].kind = KIND_ERROR;
                k = k + 2'd1;
            end else if (is_last) begin
                size_ext = EXT_W'(bp >> 3) + EXT_W'(bp[2:0] != '0) +
                           EXT_W'(FOOTER_BYTES);
                results[k].kind           = KIND_SUMMARY;
                results[k].block_index    = be;
                results[k].data_offset    = fbo;
                results[k].sync_data_size = size_ext[SIZE_W-1:0];
                results[k].ok = (outs_sum_n == 48'(cfg.total_length)) &&
                                (be == cfg.block_count) && (go == '0) && (gb == '0);
                k = k + 2'd1;
            end

            st_next.group_outs        = go;
            st_next.group_bits        = gb;
            st_next.blocks_emitted    = be;
            st_next.outs_sum          = outs_sum_n;
            st_next.first_byte_offset = fbo;
            st_next.failed            = err;
            bit_pos_next              = bp;
        end

        if (k != 2'd0) results[k - 2'd1].last = 1'b1;
        // end of map: start afresh with the registers kept
        if (is_last) begin
            st_next      = '0;
            bit_pos_next = '0;
        end
        result_count = k;
    end

endmodule

// File: hw/rtl/cbbm_out_buf.sv
// Result buffer: holds the results of one entry and hands them out one transfer at a time.
module cbbm_out_buf import cbbm_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  result_t [RESULTS_MAX-1:0] load_results,
    input  logic [1:0]                load_count,
    output logic                      free,
    output logic                      out_valid,
    input  logic                      out_ready,
    output result_t                   out_result
);

    result_t [RESULTS_MAX-1:0] slot_reg;
    logic [1:0] count_reg;
    logic [1:0] rd_reg;
    logic       pop;

    assign out_valid = (rd_reg < count_reg);
    assign pop       = out_valid && out_ready;
    assign free      = (rd_reg == count_reg) || (pop && (rd_reg + 2'd1 == count_reg));

    always_comb begin
        unique case (rd_reg)
            2'd0:    out_result = slot_reg[0];
            2'd1:    out_result = slot_reg[1];
            default: out_result = slot_reg[2];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            rd_reg    <= '0;
        end else if (load) begin
            count_reg <= load_count;
            rd_reg    <= '0;
        end else if (pop) begin
            rd_reg <= rd_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) slot_reg <= load_results;
    end

endmodule
